// ===== design/ifbc_pkg.sv =====
package ifbc_pkg;

    localparam int COUNT_WIDTH_DEF    = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    localparam int Q_W       = 16;  // quaternion component
    localparam int A_W       = 16;  // raw acceleration
    localparam int OUT_W     = 18;  // result / bias
    localparam int VEC_W     = 19;  // multiplier vector operand
    localparam int SUM_W     = 34;  // accumulated world sums
    localparam int TGT_W     = 16;  // sample_target register
    localparam int PROD_W    = 32;  // quaternion products
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 18;
    localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
    localparam int TGT_RESET = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET,
        CFG_BIAS_X,
        CFG_BIAS_Y,
        CFG_BIAS_Z
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_MAT,
        ST_ROT,
        ST_ACCUM,
        ST_DIVST,
        ST_DIV,
        ST_DIFF_OUT
    } state_t;

    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] quotient;
    } div_res_t;

endpackage

// ===== design/ifbc_if.sv =====
interface ifbc_in_if
    import ifbc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic signed [Q_W-1:0] quat_w;
    logic signed [Q_W-1:0] quat_x;
    logic signed [Q_W-1:0] quat_y;
    logic signed [Q_W-1:0] quat_z;
    logic signed [A_W-1:0] accel_in_x;
    logic signed [A_W-1:0] accel_in_y;
    logic signed [A_W-1:0] accel_in_z;

    modport source (output valid, mode, quat_w, quat_x, quat_y, quat_z,
                    accel_in_x, accel_in_y, accel_in_z, input ready);
    modport sink   (input valid, mode, quat_w, quat_x, quat_y, quat_z,
                    accel_in_x, accel_in_y, accel_in_z, output ready);
endinterface

interface ifbc_out_if
    import ifbc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] accel_out_x;
    logic signed [OUT_W-1:0] accel_out_y;
    logic signed [OUT_W-1:0] accel_out_z;
    logic                    was_calibrating;
    logic                    calibration_done;

    modport source (output valid, accel_out_x, accel_out_y, accel_out_z,
                    was_calibrating, calibration_done, input ready);
    modport sink   (input valid, accel_out_x, accel_out_y, accel_out_z,
                    was_calibrating, calibration_done, output ready);
endinterface

// ===== design/ifbc_div.sv =====
// Restoring divider, one quotient bit per cycle; signed dividend, truncates
// toward zero, quotient saturated to OUT_W.
module ifbc_div
    import ifbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic        [TGT_W-1:0] divisor,
    output div_res_t                res
);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    logic              busy_reg, done_reg, neg_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [TGT_W-1:0]  rem_reg, dsr_reg;
    logic [TGT_W:0]    rem_sh, rem_sub;
    logic              ge;
    logic [SUM_W-1:0]  mag_next;

    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub  = rem_sh - {1'b0, dsr_reg};
    assign mag_next = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag_next;
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[TGT_W-1:0] : rem_sh[TGT_W-1:0];
        end
    end

    always_comb
    begin
        res.done = done_reg;
        if (!neg_reg)
            res.quotient = (quo_reg > SUM_W'(OUT_MAX)) ? OUT_W'(OUT_MAX)
                                                       : OUT_W'(quo_reg);
        else
            res.quotient = (quo_reg > SUM_W'(OUT_MAX + 1)) ? OUT_W'(-OUT_MAX - 1)
                                                           : OUT_W'(-quo_reg);
    end

endmodule

// ===== design/imu_frame_bias_calibrator_core.sv =====
// Channel   Dir  Payload                                        Handshake
// sample    in   mode, quat_w/x/y/z, accel_in_x/y/z             valid/ready
// result    out  accel_out_x/y/z, was_calibrating, cal_done     valid/ready
// cfg       in   cfg_index, cfg_data                            cfg_we only
//
// A sample passes through the product, matrix and rotate steps, then an accumulate
// step while calibrating, or a difference step and a back-rotate when correcting,
// then the output load; a new sample is accepted only after that load. The
// completing calibration sample adds three divides, one per axis. The one
// shared multiplier serves the product and rotate steps. A start command gives
// no result.
// Reset (rst_n, async) leaves the block idle, not calibrating, target 100.
// A stalled result holds; the next sample is taken while it waits.
module imu_frame_bias_calibrator_core
    import ifbc_pkg::*;
#(
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ifbc_in_if.sink              sample,
    ifbc_out_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int F     = QUAT_FRAC_BITS;
    // matrix entry width: rounded product sum, or the diagonal "one"
    localparam int ME_W  = (36 - F > F + 2) ? 36 - F : F + 2;
    localparam int MUL_W = ME_W + VEC_W;
    localparam int ACC_W = MUL_W + 2;
    localparam int CMP_W = (COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W;
    localparam logic signed [34:0]    HALF_E = 35'sd1 <<< (F - 1);
    localparam logic signed [34:0]    ONE_E  = 35'sd1 <<< F;
    localparam logic signed [ACC_W:0] HALF_A = (ACC_W + 1)'(1) <<< (F - 1);

    state_t state_reg, state_next;

    // control
    logic                   cal_flag_reg;
    logic [COUNT_WIDTH-1:0] taken_reg;
    logic [TGT_W-1:0]       target_reg;
    logic [3:0]             k_reg;
    logic [1:0]             row_reg, col_reg, div_idx_reg;
    logic                   back_reg;
    logic                   out_valid_reg;

    // datapath
    logic signed [Q_W-1:0]    q_reg   [4];
    logic signed [A_W-1:0]    a_reg   [3];
    logic signed [PROD_W-1:0] prod_reg[9];
    logic signed [ME_W-1:0]   m_reg   [9];
    logic signed [VEC_W-1:0]  vec_reg [3];
    logic signed [OUT_W-1:0]  res_reg [3];
    logic signed [OUT_W-1:0]  bias_reg[3];
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     was_cal_reg, done_reg;
    logic signed [OUT_W-1:0]  ox_reg, oy_reg, oz_reg;
    logic                     owc_reg, ocd_reg;

    // shared multiplier
    logic signed [ME_W-1:0]  mul_a;
    logic signed [VEC_W-1:0] mul_b;
    logic signed [MUL_W-1:0] mul_p;
    logic [1:0]              qa, qb, csel;
    logic [3:0]              m_idx;

    // matrix entry logic
    logic [3:0]              pa, pb;
    logic                    e_sub, e_diag;
    logic signed [PROD_W:0]  e_sum;
    logic signed [34:0]      e_rnd;
    logic signed [ME_W-1:0]  entry;

    // row finish
    logic signed [ACC_W:0]   acc_rnd;
    logic signed [OUT_W-1:0] acc_sat;

    // calibration
    logic [COUNT_WIDTH-1:0]  taken_new;
    logic [TGT_W-1:0]        target_eff;
    logic                    cal_done;
    logic                    accept, last_row, out_free, out_load;
    div_res_t                div_res;

    ifbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIVST),
        .dividend (sum_reg[div_idx_reg]),
        .divisor  (target_eff),
        .res      (div_res)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign last_row     = (row_reg == 2'd2) && (col_reg == 2'd3);
    // result register takes the finished transaction
    assign out_load     = (state_reg == ST_DIFF_OUT) && (back_reg || was_cal_reg) && out_free;

    // product table: xx yy zz xy xz yz wx wy wz (w=0 x=1 y=2 z=3)
    always_comb
    begin
        case (k_reg)
            4'd0:    begin qa = 2'd1; qb = 2'd1; end
            4'd1:    begin qa = 2'd2; qb = 2'd2; end
            4'd2:    begin qa = 2'd3; qb = 2'd3; end
            4'd3:    begin qa = 2'd1; qb = 2'd2; end
            4'd4:    begin qa = 2'd1; qb = 2'd3; end
            4'd5:    begin qa = 2'd2; qb = 2'd3; end
            4'd6:    begin qa = 2'd0; qb = 2'd1; end
            4'd7:    begin qa = 2'd0; qb = 2'd2; end
            default: begin qa = 2'd0; qb = 2'd3; end
        endcase
    end

    assign csel  = (col_reg == 2'd3) ? 2'd0 : col_reg;
    assign m_idx = back_reg ? 4'(csel * 3 + row_reg) : 4'(row_reg * 3 + csel);

    always_comb
    begin
        if (state_reg == ST_PROD)
        begin
            mul_a = ME_W'(q_reg[qa]);
            mul_b = VEC_W'(q_reg[qb]);
        end
        else
        begin
            mul_a = m_reg[m_idx];
            mul_b = vec_reg[csel];
        end
    end

    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

    // matrix entry k: row-major R from product indexes
    always_comb
    begin
        case (k_reg)
            4'd0:    begin pa = 4'd1; pb = 4'd2; e_sub = 1'b0; e_diag = 1'b1; end
            4'd1:    begin pa = 4'd3; pb = 4'd8; e_sub = 1'b1; e_diag = 1'b0; end
            4'd2:    begin pa = 4'd4; pb = 4'd7; e_sub = 1'b0; e_diag = 1'b0; end
            4'd3:    begin pa = 4'd3; pb = 4'd8; e_sub = 1'b0; e_diag = 1'b0; end
            4'd4:    begin pa = 4'd0; pb = 4'd2; e_sub = 1'b0; e_diag = 1'b1; end
            4'd5:    begin pa = 4'd5; pb = 4'd6; e_sub = 1'b1; e_diag = 1'b0; end
            4'd6:    begin pa = 4'd4; pb = 4'd7; e_sub = 1'b1; e_diag = 1'b0; end
            4'd7:    begin pa = 4'd5; pb = 4'd6; e_sub = 1'b0; e_diag = 1'b0; end
            default: begin pa = 4'd0; pb = 4'd1; e_sub = 1'b0; e_diag = 1'b1; end
        endcase
    end

    always_comb
    begin
        e_sum = e_sub ? (PROD_W + 1)'(prod_reg[pa]) - (PROD_W + 1)'(prod_reg[pb])
                      : (PROD_W + 1)'(prod_reg[pa]) + (PROD_W + 1)'(prod_reg[pb]);
        // 2*sum, then round to nearest, ties up
        e_rnd = ((35'(e_sum) <<< 1) + HALF_E) >>> F;
        entry = e_diag ? ME_W'(ONE_E - e_rnd) : ME_W'(e_rnd);
    end

    always_comb
    begin
        acc_rnd = ((ACC_W + 1)'(acc_reg) + HALF_A) >>> F;
        if (acc_rnd > (ACC_W + 1)'(OUT_MAX))
            acc_sat = OUT_W'(OUT_MAX);
        else if (acc_rnd < (ACC_W + 1)'(-OUT_MAX - 1))
            acc_sat = OUT_W'(-OUT_MAX - 1);
        else
            acc_sat = OUT_W'(acc_rnd);
    end

    assign taken_new  = (taken_reg == '1) ? taken_reg : taken_reg + 1'b1;
    assign target_eff = (target_reg == '0) ? TGT_W'(1) : target_reg;
    assign cal_done   = CMP_W'(taken_new) >= CMP_W'(target_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && !sample.mode)
                    state_next = ST_PROD;
            ST_PROD:
                if (k_reg == 4'd8)
                    state_next = ST_MAT;
            ST_MAT:
                if (k_reg == 4'd8)
                    state_next = ST_ROT;
            ST_ROT:
                if (last_row)
                begin
                    if (back_reg)
                        state_next = ST_DIFF_OUT;
                    else if (cal_flag_reg)
                        state_next = ST_ACCUM;
                    else
                        state_next = ST_DIFF_OUT;
                end
            ST_ACCUM:
                state_next = cal_done ? ST_DIVST : ST_DIFF_OUT;
            ST_DIVST:
                state_next = ST_DIV;
            ST_DIV:
                if (div_res.done)
                    state_next = (div_idx_reg == 2'd2) ? ST_DIFF_OUT : ST_DIVST;
            ST_DIFF_OUT:
                // back_reg low and not passthrough: build d, run back pass
                if (!back_reg && !was_cal_reg)
                    state_next = ST_ROT;
                else if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_flag_reg  <= 1'b0;
            taken_reg     <= '0;
            target_reg    <= TGT_W'(TGT_RESET);
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            div_idx_reg   <= '0;
            back_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                bias_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TARGET: target_reg  <= cfg_data[TGT_W-1:0];
                    CFG_BIAS_X: bias_reg[0] <= OUT_W'(cfg_data);
                    CFG_BIAS_Y: bias_reg[1] <= OUT_W'(cfg_data);
                    CFG_BIAS_Z: bias_reg[2] <= OUT_W'(cfg_data);
                    default:    ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    k_reg    <= '0;
                    row_reg  <= '0;
                    col_reg  <= '0;
                    back_reg <= 1'b0;
                    if (accept && sample.mode)
                    begin
                        cal_flag_reg <= 1'b1;
                        taken_reg    <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i]  <= '0;
                            bias_reg[i] <= '0;
                        end
                    end
                end
                ST_PROD, ST_MAT:
                    k_reg <= (k_reg == 4'd8) ? 4'd0 : k_reg + 1'b1;
                ST_ROT:
                begin
                    col_reg <= col_reg + 1'b1;
                    if (col_reg == 2'd3)
                        row_reg <= row_reg + 1'b1;
                end
                ST_ACCUM:
                begin
                    taken_reg   <= taken_new;
                    div_idx_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        logic signed [SUM_W:0] s;
                        s = (SUM_W + 1)'(sum_reg[i]) + (SUM_W + 1)'(res_reg[i]);
                        if (s[SUM_W] != s[SUM_W-1])
                            sum_reg[i] <= s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                                   : {1'b0, {(SUM_W - 1){1'b1}}};
                        else
                            sum_reg[i] <= s[SUM_W-1:0];
                    end
                    if (cal_done)
                        cal_flag_reg <= 1'b0;
                end
                ST_DIV:
                    if (div_res.done)
                    begin
                        bias_reg[div_idx_reg] <= div_res.quotient;
                        div_idx_reg <= div_idx_reg + 1'b1;
                    end
                ST_DIFF_OUT:
                    if (!back_reg && !was_cal_reg)
                    begin
                        back_reg <= 1'b1;
                        row_reg  <= '0;
                        col_reg  <= '0;
                    end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (accept && !sample.mode)
                begin
                    q_reg[0]    <= sample.quat_w;
                    q_reg[1]    <= sample.quat_x;
                    q_reg[2]    <= sample.quat_y;
                    q_reg[3]    <= sample.quat_z;
                    a_reg[0]    <= sample.accel_in_x;
                    a_reg[1]    <= sample.accel_in_y;
                    a_reg[2]    <= sample.accel_in_z;
                    vec_reg[0]  <= VEC_W'(sample.accel_in_x);
                    vec_reg[1]  <= VEC_W'(sample.accel_in_y);
                    vec_reg[2]  <= VEC_W'(sample.accel_in_z);
                    was_cal_reg <= cal_flag_reg;
                    done_reg    <= 1'b0;
                    acc_reg     <= '0;
                end
            ST_PROD:
                prod_reg[k_reg] <= mul_p[PROD_W-1:0];
            ST_MAT:
                m_reg[k_reg] <= entry;
            ST_ROT:
                if (col_reg == 2'd3)
                begin
                    res_reg[row_reg] <= acc_sat;
                    acc_reg          <= '0;
                end
                else
                    acc_reg <= acc_reg + ACC_W'(mul_p);
            ST_ACCUM:
                done_reg <= cal_done;
            ST_DIFF_OUT:
                if (!back_reg && !was_cal_reg)
                begin
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= VEC_W'(res_reg[i]) - VEC_W'(bias_reg[i]);
                end
                else if (out_free)
                begin
                    ox_reg  <= was_cal_reg ? OUT_W'(a_reg[0]) : res_reg[0];
                    oy_reg  <= was_cal_reg ? OUT_W'(a_reg[1]) : res_reg[1];
                    oz_reg  <= was_cal_reg ? OUT_W'(a_reg[2]) : res_reg[2];
                    owc_reg <= was_cal_reg;
                    ocd_reg <= done_reg;
                end
            default: ;
        endcase
    end

    assign result.valid            = out_valid_reg;
    assign result.accel_out_x      = ox_reg;
    assign result.accel_out_y      = oy_reg;
    assign result.accel_out_z      = oz_reg;
    assign result.was_calibrating  = owc_reg;
    assign result.calibration_done = ocd_reg;

endmodule

// ===== design/ifbc_checker.sv =====
module ifbc_checker
    import ifbc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    in_mode,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] out_x,
    input logic                    out_wc,
    input logic                    out_cd
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x))
        else $error("stalled result changed");

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_mode |=> !in_ready)
        else $error("ready right after a sample transaction");

    a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_mode |=> !$rose(out_valid))
        else $error("command produced a result");

    a_done_is_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_cd |-> out_wc)
        else $error("calibration_done without was_calibrating");

endmodule

bind imu_frame_bias_calibrator_core ifbc_checker u_ifbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_mode   (sample.mode),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.accel_out_x),
    .out_wc    (result.was_calibrating),
    .out_cd    (result.calibration_done)
);

// ===== tb/imu_frame_bias_calibrator_core_tb.sv =====
`timescale 1ns / 1ps

module imu_frame_bias_calibrator_core_tb;
    import ifbc_pkg::*;

    localparam int F = QUAT_FRAC_BITS_DEF;
    localparam longint CNT_MAX = (64'sd1 <<< COUNT_WIDTH_DEF) - 1;

    // one sample-channel transaction
    typedef struct {
        bit                    mode;
        logic signed [Q_W-1:0] q[4];   // w, x, y, z
        logic signed [A_W-1:0] a[3];
    } imu_item_t;

    // one result-channel transaction
    typedef struct {
        logic signed [OUT_W-1:0] acc[3];
        bit                      passthru;
        bit                      done;
    } corr_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ifbc_in_if  smp ();
    ifbc_out_if res ();

    imu_frame_bias_calibrator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int n_errors = 0;
    int send_idle = 0;     // percent of cycles the sender idles
    int recv_idle = 0;     // percent of cycles the receiver stalls
    int hold_off = 0;      // forced receiver stall, in cycles

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        n_errors++;
    endtask

    // Bias calibrator model plus the queue of corrected vectors still owed.
    class bias_scoreboard;
        longint    target;
        bit        calib;
        longint    taken;
        longint    wsum[3];
        longint    bias[3];
        corr_res_t owed[$];

        function new();
            target = TGT_RESET;
            calib  = 0;
            taken  = 0;
            for (int i = 0; i < 3; i++)
            begin
                wsum[i] = 0;
                bias[i] = 0;
            end
        endfunction

        static function longint sat(longint v, int w);
            longint hi;
            hi = (64'sd1 <<< (w - 1)) - 1;
            return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
        endfunction

        // shift right by F, round half up
        static function longint rshift_rnd(longint v);
            return (v + (64'sd1 <<< (F - 1))) >>> F;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
            case (idx)
                CFG_TARGET: target = d[TGT_W-1:0];
                CFG_BIAS_X: bias[0] = $signed(d);
                CFG_BIAS_Y: bias[1] = $signed(d);
                CFG_BIAS_Z: bias[2] = $signed(d);
                default: ;
            endcase
        endfunction

        function void note_sample(imu_item_t it);
            longint w, x, y, z, one, acc, tgt;
            longint m[3][3];
            longint wv[3];
            longint dv[3];
            corr_res_t r;
            bit fin;
            if (it.mode)
            begin
                // start (or restart) a calibration run, no result
                calib = 1;
                taken = 0;
                for (int i = 0; i < 3; i++)
                begin
                    wsum[i] = 0;
                    bias[i] = 0;
                end
                return;
            end
            w = it.q[0]; x = it.q[1]; y = it.q[2]; z = it.q[3];
            one = 64'sd1 <<< F;
            m[0][0] = one - rshift_rnd(2 * (y * y + z * z));
            m[0][1] = rshift_rnd(2 * (x * y - w * z));
            m[0][2] = rshift_rnd(2 * (x * z + w * y));
            m[1][0] = rshift_rnd(2 * (x * y + w * z));
            m[1][1] = one - rshift_rnd(2 * (x * x + z * z));
            m[1][2] = rshift_rnd(2 * (y * z - w * x));
            m[2][0] = rshift_rnd(2 * (x * z - w * y));
            m[2][1] = rshift_rnd(2 * (y * z + w * x));
            m[2][2] = one - rshift_rnd(2 * (x * x + y * y));
            for (int i = 0; i < 3; i++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += m[i][j] * longint'(it.a[j]);
                wv[i] = sat(rshift_rnd(acc), OUT_W);
            end
            if (calib)
            begin
                tgt = (target == 0) ? 1 : target;
                fin = 0;
                for (int i = 0; i < 3; i++)
                    wsum[i] = sat(wsum[i] + wv[i], SUM_W);
                if (taken < CNT_MAX)
                    taken++;
                if (taken >= tgt)
                begin
                    for (int i = 0; i < 3; i++)
                        bias[i] = sat(wsum[i] / tgt, OUT_W);  // truncates toward zero
                    calib = 0;
                    fin = 1;
                end
                for (int i = 0; i < 3; i++)
                    r.acc[i] = OUT_W'(it.a[i]);
                r.passthru = 1;
                r.done = fin;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    dv[i] = wv[i] - bias[i];
                for (int i = 0; i < 3; i++)
                begin
                    acc = 0;
                    for (int j = 0; j < 3; j++)
                        acc += m[j][i] * dv[j];   // transposed matrix
                    r.acc[i] = OUT_W'(sat(rshift_rnd(acc), OUT_W));
                end
                r.passthru = 0;
                r.done = 0;
            end
            owed.push_back(r);
        endfunction

        task check_result(corr_res_t got);
            corr_res_t e;
            if (owed.size() == 0)
            begin
                report("result with nothing expected");
                return;
            end
            e = owed.pop_front();
            for (int i = 0; i < 3; i++)
                if (got.acc[i] !== e.acc[i])
                    report($sformatf("accel_out[%0d] got %0d exp %0d", i, got.acc[i], e.acc[i]));
            if (got.passthru !== e.passthru)
                report($sformatf("was_calibrating got %0b exp %0b", got.passthru, e.passthru));
            if (got.done !== e.done)
                report($sformatf("calibration_done got %0b exp %0b", got.done, e.done));
        endtask
    endclass

    bias_scoreboard sb;

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // hard limit on the run
    initial
    begin
        #30ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: stalls at random, or for a forced stretch
    initial
    begin
        res.ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                res.ready = 0;
                hold_off--;
            end
            else
                res.ready = ($urandom % 100) >= recv_idle;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        corr_res_t got;
        if (rst_n && res.valid && res.ready)
        begin
            got.acc[0] = res.accel_out_x;
            got.acc[1] = res.accel_out_y;
            got.acc[2] = res.accel_out_z;
            got.passthru = res.was_calibrating;
            got.done = res.calibration_done;
            sb.check_result(got);
        end
    end

    // one sample transaction; valid stays high into the next call
    task automatic send(input imu_item_t it);
        while (($urandom % 100) < send_idle)
        begin
            smp.valid = 0;
            @(negedge clk);
        end
        smp.mode = it.mode;
        smp.quat_w = it.q[0];
        smp.quat_x = it.q[1];
        smp.quat_y = it.q[2];
        smp.quat_z = it.q[3];
        smp.accel_in_x = it.a[0];
        smp.accel_in_y = it.a[1];
        smp.accel_in_z = it.a[2];
        smp.valid = 1;
        do
            @(posedge clk);
        while (!smp.ready);
        sb.note_sample(it);
        @(negedge clk);
    endtask

    // drain: nothing owed, then allow a command or divide still in flight
    task automatic drain();
        smp.valid = 0;
        while (sb.owed.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val[CFG_W-1:0];
        @(negedge clk);
        cfg_we = 0;
        sb.write_reg(idx, cfg_data);
    endtask

    function automatic imu_item_t mk(bit md, int w, int x, int y, int z,
                                     int ax, int ay, int az);
        imu_item_t it;
        it.mode = md;
        it.q[0] = Q_W'(w); it.q[1] = Q_W'(x); it.q[2] = Q_W'(y); it.q[3] = Q_W'(z);
        it.a[0] = A_W'(ax); it.a[1] = A_W'(ay); it.a[2] = A_W'(az);
        return it;
    endfunction

    function automatic int rand_quat();
        case ($urandom % 5)
            0: return 16384;
            1: return -16384;
            2: return 0;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    function automatic imu_item_t rand_item(int start_pct);
        imu_item_t it;
        it.mode = ($urandom % 100) < start_pct;
        if (($urandom % 4) == 0)
        begin
            // axis-aligned unit rotation, gives realistic world vectors
            for (int k = 0; k < 4; k++)
                it.q[k] = '0;
            it.q[$urandom % 4] = ($urandom % 2) ? Q_W'(16384) : Q_W'(-16384);
        end
        else
            for (int k = 0; k < 4; k++)
                it.q[k] = Q_W'(rand_quat());
        for (int k = 0; k < 3; k++)
            it.a[k] = A_W'($urandom);
        return it;
    endfunction

    function automatic int rand_bias();
        case ($urandom % 4)
            0: return 131071;
            1: return -131072;
            default: return int'($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    initial
    begin
        int tgts[6];
        sb = new();
        cfg_we = 0;
        cfg_index = CFG_TARGET;
        cfg_data = '0;
        smp.valid = 0;
        smp.mode = 0;
        smp.quat_w = 0;
        smp.quat_x = 0;
        smp.quat_y = 0;
        smp.quat_z = 0;
        smp.accel_in_x = 0;
        smp.accel_in_y = 0;
        smp.accel_in_z = 0;
        rst_n = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;
        repeat (300) @(negedge clk);

        // directed part: presets at the rails, field extremes, a short run
        send_idle = 19;
        recv_idle = 72;
        write_reg(CFG_TARGET, 2);
        write_reg(CFG_BIAS_X, 131071);
        write_reg(CFG_BIAS_Y, -131072);
        write_reg(CFG_BIAS_Z, 0);
        send(mk(0, 16384, 0, 0, 0, 32767, -32768, 0));
        send(mk(0, -16384, 0, 0, 0, -32768, 32767, -1));
        send(mk(0, 16384, 16384, 16384, 16384, 32767, 32767, 32767));   // non-unit
        send(mk(0, -16384, -16384, -16384, -16384, -32768, -32768, -32768));
        send(mk(0, 0, 0, 0, 0, 12345, -54321 + 65536, 1));              // zero quaternion
        send(mk(0, 0, 16384, 0, 0, 100, 200, 300));
        send(mk(0, 0, 0, 16384, 0, -100, 200, -300));
        send(mk(0, 0, 0, 0, 16384, 32767, 0, -32768));
        send(mk(1, 0, 0, 0, 0, 0, 0, 0));                               // start
        send(mk(0, 16384, 0, 0, 0, 1000, -2000, 16384));
        send(mk(1, 0, 0, 0, 0, 0, 0, 0));                               // restart mid-run
        send(mk(0, 11585, 11585, 0, 0, 32767, 32767, -32768));
        send(mk(0, 16384, 0, 0, 0, -32768, -32768, 32767));             // completes
        send(mk(0, 16384, 0, 0, 0, 0, 0, 0));
        send(mk(0, 11585, 0, 0, -11585, 5000, -7000, 16000));
        send(mk(1, 0, 0, 0, 0, 0, 0, 0));
        send(mk(0, 16384, 0, 0, 0, 32767, 32767, 32767));
        drain();
        write_reg(CFG_TARGET, 1);                                       // preset during a run
        write_reg(CFG_BIAS_Z, -5);
        send(mk(0, 16384, 0, 0, 0, -32768, -32768, -32768));            // completes at once
        send(mk(0, 16384, 0, 0, 0, 1, 2, 3));
        drain();

        // random phases; targets include zero and the maximum
        tgts = '{1, 4, 0, 65535, 3, 0};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_TARGET, (ph == 5) ? int'($urandom_range(2, 12)) : tgts[ph]);
            write_reg(CFG_BIAS_X, rand_bias());
            write_reg(CFG_BIAS_Y, rand_bias());
            write_reg(CFG_BIAS_Z, rand_bias());
            send_idle = (ph < 2) ? 19 : (ph < 4) ? 72 : 0;
            recv_idle = (ph < 2) ? 72 : (ph < 4) ? 19 : 0;
            if (ph == 1)
                hold_off = 600;     // let the block back up onto its input
            for (int n = 0; n < 240; n++)
            begin
                if (ph == 3 && n == 120)
                    while (sb.owed.size() != 0)
                    begin
                        smp.valid = 0;
                        @(negedge clk);
                    end
                send(rand_item(ph == 3 ? 1 : 12));
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (n_errors == 0 && sb.owed.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
